@@ design/tach_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_pkg
// Shared widths, reset values, codes and structures of the pulse tachometer.
// ----------------------------------------------------------------------------
package tach_pkg;

   localparam int unsigned ADC_W      = 12;
   localparam int unsigned WIN_W      = 16;
   localparam int unsigned INT_W      = 8;
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned RPM_W      = 16;
   localparam int unsigned PROD_W     = 32;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;

   localparam int unsigned ADC_BITS_DEFAULT = 12;

   localparam logic [ADC_W-1:0] THRESHOLD_RESET = 12'd1240;
   localparam logic [WIN_W-1:0] WINDOW_RESET    = 16'd1000;
   localparam logic [INT_W-1:0] INTERVAL_RESET  = 8'd5;

   // ms per minute
   localparam logic [RPM_W-1:0] RPM_SCALE = 16'd60000;

   localparam int unsigned DIV_STEPS = PROD_W;
   localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WINDOW    = 2'd1,
      CSR_INTERVAL  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_SAMPLING = 2'd1,
      PH_PROCESS  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      S_ACCEPT = 2'd0,
      S_DIV    = 2'd1,
      S_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      logic [ADC_W-1:0] threshold_code;
      logic [WIN_W-1:0] window_ms;
      logic [INT_W-1:0] sample_interval;
   } cfg_type;

   typedef struct packed {
      logic step;
      logic start;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic finish_item;
      logic div_last;
   } stat_type;

   typedef struct packed {
      logic             status;
      logic             measure_done;
      logic [RPM_W-1:0] rpm;
      logic [CNT_W-1:0] pulses;
      logic             signal_seen;
      logic [ADC_W-1:0] final_adc;
      logic             busy_res;
   } rsp_payload_type;

endpackage

@@ design/tach_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_if
// Valid/ready channels of the tachometer: request items and response items.
// ----------------------------------------------------------------------------
interface tach_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [tach_pkg::ADC_W-1:0] adc_sample;

   modport source (output valid, output req_type, output adc_sample, input ready);
   modport sink   (input valid, input req_type, input adc_sample, output ready);
endinterface

interface tach_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      status;
   logic                      measure_done;
   logic [tach_pkg::RPM_W-1:0] rpm;
   logic [tach_pkg::CNT_W-1:0] pulses;
   logic                      signal_seen;
   logic [tach_pkg::ADC_W-1:0] final_adc;
   logic                      busy_res;

   modport source (output valid, output status, output measure_done, output rpm,
                   output pulses, output signal_seen, output final_adc,
                   output busy_res, input ready);
   modport sink   (input valid, input status, input measure_done, input rpm,
                   input pulses, input signal_seen, input final_adc,
                   input busy_res, output ready);
endinterface

@@ design/tach_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_csr
// APB-style register file: threshold, window length and sample interval.
// ----------------------------------------------------------------------------
module tach_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tach_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tach_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tach_pkg::CSR_DATA_W-1:0] prdata,
   output tach_pkg::cfg_type               cfg
);
   import tach_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en = psel && penable && pwrite;
   assign cfg   = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_THRESHOLD: cfg_in.threshold_code  = pwdata[ADC_W-1:0];
            CSR_WINDOW:    cfg_in.window_ms       = pwdata[WIN_W-1:0];
            CSR_INTERVAL:  cfg_in.sample_interval = pwdata[INT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_THRESHOLD: prdata = CSR_DATA_W'(cfg_ff.threshold_code);
         CSR_WINDOW:    prdata = CSR_DATA_W'(cfg_ff.window_ms);
         CSR_INTERVAL:  prdata = CSR_DATA_W'(cfg_ff.sample_interval);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_code  <= THRESHOLD_RESET;
         cfg_ff.window_ms       <= WINDOW_RESET;
         cfg_ff.sample_interval <= INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/tach_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_ctrl
// Sequencer: takes items, runs the rpm division and issues the final push.
// ----------------------------------------------------------------------------
module tach_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               space,
   input  tach_pkg::stat_type stat,
   output tach_pkg::cmd_type  cmd
);
   import tach_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_ACCEPT: begin
            req_ready = space;
            if (req_valid && space) begin
               if (stat.finish_item) begin
                  cmd.start = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_ACCEPT;
         end
         default: state_in = S_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_finish_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> $past(state_ff == S_DIV && stat.div_last))
      else $error("finish without completed division");

   a_start_only_finishing: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (req_valid && space && stat.finish_item))
      else $error("division started without a completing item");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_ACCEPT) |-> !req_ready)
      else $error("item taken during division");

endmodule

@@ design/tach_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_dp
// Window counters, edge detection, held result and the serial rpm divider.
// ----------------------------------------------------------------------------
module tach_dp #(
   parameter int unsigned ADC_BITS = tach_pkg::ADC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tach_pkg::cmd_type          cmd,
   input  tach_pkg::cfg_type          cfg,
   input  logic                       req_type,
   input  logic [tach_pkg::ADC_W-1:0] adc_sample,
   output tach_pkg::stat_type         stat,
   output logic                       push,
   output tach_pkg::rsp_payload_type  push_data
);
   import tach_pkg::*;

   localparam int unsigned      ADC_KEEP = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
   localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((1 << ADC_KEEP) - 1);

   phase_type         phase_ff, phase_in;
   logic [WIN_W-1:0]  elapsed_ff, elapsed_in;
   logic [INT_W-1:0]  tss_ff, tss_in;
   logic [CNT_W-1:0]  edge_ff, edge_in;
   logic              prev_ff, prev_in;
   logic              seen_ff, seen_in;
   logic [RPM_W-1:0]  held_rpm_ff, held_rpm_in;
   logic [CNT_W-1:0]  held_pulses_ff, held_pulses_in;
   logic              held_seen_ff, held_seen_in;
   logic [ADC_W-1:0]  held_adc_ff, held_adc_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [WIN_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [ADC_W-1:0]  fin_adc_ff, fin_adc_in;

   logic [ADC_W-1:0]  sample;
   logic [WIN_W-1:0]  elapsed_inc;
   logic [INT_W-1:0]  tss_inc;
   logic              level;
   logic [PROD_W-1:0] product;
   logic [WIN_W:0]    rem_shift;
   logic [WIN_W:0]    rem_diff;
   logic              status;

   assign sample      = adc_sample & ADC_MASK;
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign tss_inc     = (tss_ff == '1) ? tss_ff : tss_ff + 1'b1;
   assign level       = sample > cfg.threshold_code;
   assign product     = PROD_W'(edge_ff) * PROD_W'(RPM_SCALE);
   assign rem_shift   = {rem_ff, quo_ff[PROD_W-1]};
   assign rem_diff    = rem_shift - {1'b0, cfg.window_ms};

   assign stat.finish_item = (phase_ff == PH_PROCESS) && !req_type;
   assign stat.div_last    = (dcnt_ff == DCNT_W'(DIV_STEPS - 1));

   always_comb begin
      phase_in       = phase_ff;
      elapsed_in     = elapsed_ff;
      tss_in         = tss_ff;
      edge_in        = edge_ff;
      prev_in        = prev_ff;
      seen_in        = seen_ff;
      held_rpm_in    = held_rpm_ff;
      held_pulses_in = held_pulses_ff;
      held_seen_in   = held_seen_ff;
      held_adc_in    = held_adc_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      dcnt_in        = dcnt_ff;
      fin_adc_in     = fin_adc_ff;
      status         = 1'b0;

      if (cmd.step) begin
         if (req_type) begin
            if (phase_ff == PH_IDLE) begin
               elapsed_in = '0;
               tss_in     = '0;
               edge_in    = '0;
               prev_in    = 1'b0;
               seen_in    = 1'b0;
               phase_in   = PH_SAMPLING;
            end else begin
               status = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               PH_SAMPLING: begin
                  elapsed_in = elapsed_inc;
                  tss_in     = tss_inc;
                  if (elapsed_inc >= cfg.window_ms) begin
                     phase_in = PH_PROCESS;
                  end else begin
                     status = 1'b1;
                     if (tss_inc >= cfg.sample_interval) begin
                        if (level && !prev_ff && (edge_ff != '1)) begin
                           edge_in = edge_ff + 1'b1;
                        end
                        seen_in = seen_ff | level;
                        prev_in = level;
                        tss_in  = '0;
                     end
                  end
               end
               PH_PROCESS: phase_in = PH_PROCESS;
               default:    phase_in = PH_IDLE;
            endcase
         end
      end

      if (cmd.start) begin
         quo_in     = product;
         rem_in     = '0;
         dcnt_in    = '0;
         fin_adc_in = sample;
      end

      if (cmd.div_step) begin
         if (!rem_diff[WIN_W]) begin
            rem_in = rem_diff[WIN_W-1:0];
         end else begin
            rem_in = rem_shift[WIN_W-1:0];
         end
         quo_in  = {quo_ff[PROD_W-2:0], !rem_diff[WIN_W]};
         dcnt_in = dcnt_ff + 1'b1;
      end

      if (cmd.finish) begin
         held_adc_in    = fin_adc_ff;
         held_seen_in   = seen_ff;
         held_pulses_in = edge_ff;
         if (cfg.window_ms == '0) begin
            held_rpm_in = '0;
         end else if (quo_ff[PROD_W-1:RPM_W] != '0) begin
            held_rpm_in = '1;
         end else begin
            held_rpm_in = quo_ff[RPM_W-1:0];
         end
         phase_in = PH_IDLE;
      end
   end

   assign push                   = cmd.step || cmd.finish;
   assign push_data.status       = status;
   assign push_data.measure_done = cmd.finish;
   assign push_data.rpm          = held_rpm_in;
   assign push_data.pulses       = held_pulses_in;
   assign push_data.signal_seen  = held_seen_in;
   assign push_data.final_adc    = held_adc_in;
   assign push_data.busy_res     = (phase_in != PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         elapsed_ff     <= '0;
         tss_ff         <= '0;
         edge_ff        <= '0;
         prev_ff        <= 1'b0;
         seen_ff        <= 1'b0;
         held_rpm_ff    <= '0;
         held_pulses_ff <= '0;
         held_seen_ff   <= 1'b0;
         held_adc_ff    <= '0;
         dcnt_ff        <= '0;
      end else begin
         phase_ff       <= phase_in;
         elapsed_ff     <= elapsed_in;
         tss_ff         <= tss_in;
         edge_ff        <= edge_in;
         prev_ff        <= prev_in;
         seen_ff        <= seen_in;
         held_rpm_ff    <= held_rpm_in;
         held_pulses_ff <= held_pulses_in;
         held_seen_ff   <= held_seen_in;
         held_adc_ff    <= held_adc_in;
         dcnt_ff        <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      fin_adc_ff <= fin_adc_in;
   end

endmodule

@@ design/tach_rsp_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_rsp_buf
// Two-entry response buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module tach_rsp_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tach_pkg::rsp_payload_type push_data,
   output logic                      space,
   tach_rsp_if.source                rsp
);
   import tach_pkg::*;

   rsp_payload_type out_ff, out_in;
   rsp_payload_type skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   logic            pop;

   assign pop   = out_valid_ff && rsp.ready;
   assign space = !skid_valid_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = push_data;
            skid_valid_in = push;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_ff.status;
   assign rsp.measure_done = out_ff.measure_done;
   assign rsp.rpm          = out_ff.rpm;
   assign rsp.pulses       = out_ff.pulses;
   assign rsp.signal_seen  = out_ff.signal_seen;
   assign rsp.final_adc    = out_ff.final_adc;
   assign rsp.busy_res     = out_ff.busy_res;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !(skid_valid_ff && out_valid_ff && !pop))
      else $error("response buffer overflow");

endmodule

@@ design/windowed_pulse_tachometer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_pulse_tachometer
// Pulse-counting tachometer over a programmable window of millisecond ticks.
//
// req_bus carries one item per tick (req_type 0, with adc_sample) or a start
// trigger (req_type 1). Every item gives exactly one item on rsp_bus.
// Ordinary items do not hold the sequencer, and their response is registered in
// the response buffer. The tick that completes a measurement latches
// pulses*60000, runs the bit-serial restoring divider by window_ms (one
// quotient bit per cycle), then pushes the result.
// No item is taken while that division runs.
// The csr_ port writes threshold_code (0x0), window_ms (0x4) and
// sample_interval (0x8); write only while no item is outstanding.
// Reset returns to idle with zeroed counters and held result, and restores
// the register defaults.
// A stalled receiver is absorbed by a two-entry response buffer: one more
// item is still accepted while a response waits, then req_bus.ready drops
// until rsp_bus.ready frees a slot.
// ----------------------------------------------------------------------------
module windowed_pulse_tachometer #(
   parameter int unsigned ADC_BITS = tach_pkg::ADC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   tach_req_if.sink                        req_bus,
   tach_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tach_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tach_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tach_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import tach_pkg::*;

   cfg_type         cfg;
   cmd_type         cmd;
   stat_type        stat;
   logic            space;
   logic            push;
   logic            req_ready;
   rsp_payload_type push_data;

   assign csr_pready    = 1'b1;
   assign req_bus.ready = req_ready;

   tach_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   tach_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .space     (space),
      .stat      (stat),
      .cmd       (cmd)
   );

   tach_dp #(
      .ADC_BITS (ADC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .req_type   (req_bus.req_type),
      .adc_sample (req_bus.adc_sample),
      .stat       (stat),
      .push       (push),
      .push_data  (push_data)
   );

   tach_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .space     (space),
      .rsp       (rsp_bus)
   );

endmodule
